/* hdl/dmf_pkg.sv */
package dmf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENTRY,
    ST_FLUSH,
    ST_COMMIT,
    ST_OUT
  } dmf_state_t;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
  localparam logic [1:0] STATUS_LIST_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_step;  // compare one originator slot
    logic slot_take;  // claim the free slot found during the scan
    logic entry_step; // walk one entry of the slot
    logic commit;     // record the sequence number
  } dmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic slot_found;
    logic slot_free;
    logic entry_last;
    logic dup;
  } dmf_stat_t;

endpackage

/* hdl/dmf_ctrl.sv */
module dmf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dmf_pkg::dmf_cmd_t  cmd,
  input  dmf_pkg::dmf_stat_t stat,
  output logic [1:0]         res_status,
  output logic               res_dup
);
  import dmf_pkg::*;

  dmf_state_t state, state_next;
  logic [1:0] status_reg, status_next;
  logic dup_reg, dup_next;

  always_comb begin
    state_next = state;
    status_next = status_reg;
    dup_next = dup_reg;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.slot_found) begin
          state_next = ST_ENTRY;
        end else if (stat.scan_last) begin
          if (stat.slot_free) begin
            state_next = ST_ENTRY;
          end else begin
            state_next = ST_OUT;
            status_next = STATUS_TABLE_FULL;
            dup_next = 1'b0;
          end
        end
      end
      ST_ENTRY: begin
        if (stat.entry_last) state_next = ST_FLUSH;
      end
      // The last entry read returns here and is checked by the datapath.
      ST_FLUSH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_next = ST_OUT;
        dup_next = stat.dup;
        status_next = (!stat.dup && stat.slot_free) ? STATUS_LIST_FULL : STATUS_OK;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // In COMMIT, slot_free is reused by the datapath to mean "no free entry".
  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    unique case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.slot_take = !stat.slot_found && stat.scan_last && stat.slot_free;
      end
      ST_ENTRY: cmd.entry_step = 1'b1;
      ST_COMMIT: cmd.commit = !stat.dup;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    status_reg <= status_next;
    dup_reg <= dup_next;
  end

  assign res_status = status_reg;
  assign res_dup = dup_reg;
endmodule

/* hdl/dmf_data.sv */
module dmf_data #(
  parameter int ORIGINATORS = 16,
  parameter int ENTRIES_PER_ORIGINATOR = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        addr_high,
  input  logic [63:0]        addr_low,
  input  logic [15:0]        sequence_req,
  input  logic [7:0]         lifetime,
  input  logic [31:0]        now_seconds,
  input  dmf_pkg::dmf_cmd_t  cmd,
  output dmf_pkg::dmf_stat_t stat
);
  import dmf_pkg::*;

  localparam int OW = (ORIGINATORS > 1) ? $clog2(ORIGINATORS) : 1;
  localparam int EW = (ENTRIES_PER_ORIGINATOR > 1) ? $clog2(ENTRIES_PER_ORIGINATOR) : 1;
  localparam int DEPTH = ORIGINATORS * ENTRIES_PER_ORIGINATOR;
  localparam int AW = OW + EW;

  logic [63:0] orig_hi_mem [ORIGINATORS];
  logic [63:0] orig_lo_mem [ORIGINATORS];
  logic [ORIGINATORS-1:0] orig_used;
  logic [15:0] seq_mem [DEPTH];
  logic [31:0] exp_mem [DEPTH];
  logic [DEPTH-1:0] entry_used;

  logic [63:0] hi, lo;
  logic [15:0] seq;
  logic [31:0] now, expiry;
  logic [OW-1:0] scan_idx, slot, free_slot;
  logic have_free, found;
  logic [EW-1:0] eidx;
  logic [EW:0] free_e, old_e;
  logic [31:0] old_exp;
  logic dup;
  logic [32:0] sum;
  logic pend;
  logic [EW-1:0] pend_idx;
  logic [15:0] rd_seq;
  logic [31:0] rd_exp;

  // Entry address: slot times entries, plus entry index.
  function automatic logic [AW-1:0] ent_addr(input logic [OW-1:0] s, input logic [EW-1:0] e);
    logic [AW+8:0] a;
    a = (AW+9)'(s) * (AW+9)'(ENTRIES_PER_ORIGINATOR) + (AW+9)'(e);
    return a[AW-1:0];
  endfunction

  // The entry walk reads one entry per cycle and checks it in the following cycle.
  logic [AW-1:0] cur, paddr;
  logic live;
  assign cur = ent_addr(slot, eidx);
  assign paddr = ent_addr(slot, pend_idx);
  assign live = entry_used[paddr] && !(rd_exp < now);
  assign sum = {1'b0, now_seconds} + 33'(lifetime);

  assign stat.scan_last = (32'(scan_idx) == 32'(ORIGINATORS - 1));
  assign stat.slot_found = orig_used[scan_idx] && orig_hi_mem[scan_idx] == hi
                           && orig_lo_mem[scan_idx] == lo;
  assign stat.slot_free = found ? free_e[EW] : (have_free || !orig_used[scan_idx]);
  assign stat.entry_last = (32'(eidx) == 32'(ENTRIES_PER_ORIGINATOR - 1));
  assign stat.dup = dup;

  always_ff @(posedge clk) begin
    if (rst) begin
      orig_used <= '0;
      entry_used <= '0;
      found <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.entry_step;
      if (cmd.load) begin
        hi <= addr_high; lo <= addr_low; seq <= sequence_req; now <= now_seconds;
        expiry <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        scan_idx <= '0; have_free <= 1'b0; found <= 1'b0;
        eidx <= '0; free_e <= '1; old_e <= '1; dup <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (stat.slot_found) begin
          slot <= scan_idx; found <= 1'b1;
        end else begin
          if (!orig_used[scan_idx] && !have_free) begin
            have_free <= 1'b1; free_slot <= scan_idx;
          end
          if (!stat.scan_last) scan_idx <= scan_idx + 1'b1;
        end
        if (cmd.slot_take) begin
          found <= 1'b1;
          if (have_free) begin
            slot <= free_slot;
            orig_used[free_slot] <= 1'b1;
            orig_hi_mem[free_slot] <= hi; orig_lo_mem[free_slot] <= lo;
            for (int e = 0; e < ENTRIES_PER_ORIGINATOR; e++)
              entry_used[ent_addr(free_slot, EW'(e))] <= 1'b0;
          end else begin
            slot <= scan_idx;
            orig_used[scan_idx] <= 1'b1;
            orig_hi_mem[scan_idx] <= hi; orig_lo_mem[scan_idx] <= lo;
            for (int e = 0; e < ENTRIES_PER_ORIGINATOR; e++)
              entry_used[ent_addr(scan_idx, EW'(e))] <= 1'b0;
          end
        end
      end
      if (cmd.entry_step) begin
        pend_idx <= eidx;
        if (!stat.entry_last) eidx <= eidx + 1'b1;
      end
      if (pend) begin
        if (!live) begin
          entry_used[paddr] <= 1'b0;
          if (free_e[EW]) free_e <= {1'b0, pend_idx};
        end else begin
          if (rd_seq == seq) dup <= 1'b1;
          if (old_e[EW] || rd_exp < old_exp) begin
            old_e <= {1'b0, pend_idx}; old_exp <= rd_exp;
          end
        end
      end
      if (cmd.commit) begin
        eidx <= free_e[EW] ? old_e[EW-1:0] : free_e[EW-1:0];
        entry_used[ent_addr(slot, free_e[EW] ? old_e[EW-1:0] : free_e[EW-1:0])] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.entry_step) begin
      rd_seq <= seq_mem[cur];
      rd_exp <= exp_mem[cur];
    end
    if (cmd.commit) begin
      seq_mem[ent_addr(slot, free_e[EW] ? old_e[EW-1:0] : free_e[EW-1:0])] <= seq;
      exp_mem[ent_addr(slot, free_e[EW] ? old_e[EW-1:0] : free_e[EW-1:0])] <= expiry;
    end
  end
endmodule

/* hdl/duplicate_message_filter.sv */
// Channel   Dir  Payload (tdata from bit 0 / tuser)
// s_axis    in   addr_high, addr_low, sequence_req, lifetime, now_seconds
// m_axis    out  is_duplicate, status
// One item at a time: a load step, the slot scan over up to ORIGINATORS
// slots, the entry walk over ENTRIES_PER_ORIGINATOR entries plus a flush
// step for the last entry read, a commit step and an output step; when the
// originator table is full, the scan goes straight to the output step.
// The slot scan and the entry walk each check one element per cycle.
// rst clears all valid bits at once; a stalled result holds the block.
module duplicate_message_filter #(
  parameter int ORIGINATORS = 16,
  parameter int ENTRIES_PER_ORIGINATOR = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // addr_high[63:0], addr_low[127:64], sequence_req[143:128],
  // lifetime[151:144], now_seconds[183:152]
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // is_duplicate[0], status[2:1]
  output logic [7:0]   m_axis_tdata
);
  import dmf_pkg::*;

  dmf_cmd_t cmd;
  dmf_stat_t stat;
  logic [1:0] res_status;
  logic res_dup;

  dmf_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .stat(stat), .res_status(res_status), .res_dup(res_dup)
  );

  dmf_data #(
    .ORIGINATORS(ORIGINATORS),
    .ENTRIES_PER_ORIGINATOR(ENTRIES_PER_ORIGINATOR)
  ) u_data (
    .clk(clk), .rst(rst),
    .addr_high(s_axis_tdata[63:0]),
    .addr_low(s_axis_tdata[127:64]),
    .sequence_req(s_axis_tdata[143:128]),
    .lifetime(s_axis_tdata[151:144]),
    .now_seconds(s_axis_tdata[183:152]),
    .cmd(cmd), .stat(stat)
  );

  assign m_axis_tdata = {5'd0, res_status, res_dup};
endmodule

/* sim/tb.sv */
module tb;
  import dmf_pkg::*;

  localparam int NSLOT = 16;
  localparam int NENT = 8;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] seq;
    logic [7:0]  life;
    logic [31:0] now;
    logic        chk;   // typed-in result present
    logic        dup;
    logic [1:0]  stat;
  } msg_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [183:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [7:0] m_axis_tdata;

  duplicate_message_filter uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Shadow copy of the originator table and entry lists.
  logic [63:0] sh_hi [NSLOT];
  logic [63:0] sh_lo [NSLOT];
  logic        sh_used [NSLOT];
  logic [15:0] sh_seq [NSLOT*NENT];
  logic [31:0] sh_exp [NSLOT*NENT];
  logic        sh_live [NSLOT*NENT];

  logic [2:0] verdicts [$];   // {status, is_duplicate}
  int errors = 0;
  int send_idle = 10;
  int recv_idle = 74;
  logic [63:0] addr_pool_hi [24];
  logic [63:0] addr_pool_lo [24];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [2:0] filter_message(msg_t m);
    int slot = -1;
    int free_s = -1;
    int base;
    int free_e = -1;
    int oldest = -1;
    logic dup = 0;
    logic [32:0] sum;
    for (int s = 0; s < NSLOT; s++) begin
      if (sh_used[s]) begin
        if (slot < 0 && sh_hi[s] == m.hi && sh_lo[s] == m.lo) slot = s;
      end else if (free_s < 0) begin
        free_s = s;
      end
    end
    if (slot < 0) begin
      if (free_s < 0) return {STATUS_TABLE_FULL, 1'b0};
      slot = free_s;
      sh_used[slot] = 1;
      sh_hi[slot] = m.hi;
      sh_lo[slot] = m.lo;
      for (int e = 0; e < NENT; e++) sh_live[slot*NENT+e] = 0;
    end
    base = slot * NENT;
    for (int e = base; e < base + NENT; e++) begin
      if (sh_live[e] && sh_exp[e] < m.now) sh_live[e] = 0;
      if (sh_live[e]) begin
        if (sh_seq[e] == m.seq) dup = 1;
        if (oldest < 0 || sh_exp[e] < sh_exp[oldest]) oldest = e;
      end else if (free_e < 0) begin
        free_e = e;
      end
    end
    if (dup) return {STATUS_OK, 1'b1};
    sum = {1'b0, m.now} + 33'(m.life);
    sh_live[free_e < 0 ? oldest : free_e] = 1;
    sh_seq[free_e < 0 ? oldest : free_e] = m.seq;
    sh_exp[free_e < 0 ? oldest : free_e] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    return {(free_e < 0) ? STATUS_LIST_FULL : STATUS_OK, 1'b0};
  endfunction

  // tvalid stays high after an accept until the next idle cycle or pause.
  task automatic send_message(msg_t m);
    logic [2:0] v;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tdata <= {m.now, m.life, m.seq, m.lo, m.hi};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    v = filter_message(m);
    if (m.chk && v != {m.stat, m.dup}) begin
      $display("%0t predictor disagrees with typed row: expected %h got %h",
               $time, {m.stat, m.dup}, v);
      errors++;
    end
    verdicts.push_back(v);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts.size() == 0) begin
          $display("%0t unexpected result: expected none got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata[2:0] != verdicts[0]) begin
            $display("%0t mismatch: expected dup=%0d status=%0d got dup=%0d status=%0d",
                     $time, verdicts[0][0], verdicts[0][2:1],
                     m_axis_tdata[0], m_axis_tdata[2:1]);
            errors++;
          end
          void'(verdicts.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic msg_t mk(logic [63:0] hi, logic [63:0] lo, logic [15:0] seq,
                              logic [7:0] life, logic [31:0] now,
                              logic chk = 0, logic dup = 0, logic [1:0] stat = STATUS_OK);
    msg_t m;
    m.hi = hi; m.lo = lo; m.seq = seq; m.life = life; m.now = now;
    m.chk = chk; m.dup = dup; m.stat = stat;
    return m;
  endfunction

  msg_t directed [$];
  msg_t m;
  int slot_pick;
  logic [31:0] clock_now;

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    for (int s = 0; s < NSLOT; s++) sh_used[s] = 0;
    for (int e = 0; e < NSLOT*NENT; e++) sh_live[e] = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // First sighting, repeat, expiry boundary, saturation, list full, table full.
    directed.push_back(mk('0, '0, 16'h0000, 8'd0, 32'd100, 1, 0, STATUS_OK));
    directed.push_back(mk('0, '0, 16'h0000, 8'd0, 32'd100, 1, 1, STATUS_OK));
    directed.push_back(mk('0, '0, 16'h0000, 8'd0, 32'd101, 1, 0, STATUS_OK));
    directed.push_back(mk('1, '1, 16'hFFFF, 8'hFF, 32'hFFFF_FFF0, 1, 0, STATUS_OK));
    directed.push_back(mk('1, '1, 16'hFFFF, 8'd0, 32'hFFFF_FFFF, 1, 1, STATUS_OK));
    for (int i = 1; i <= 8; i++)
      directed.push_back(mk(64'h5, 64'hA, 16'(i), 8'(10 - i), 32'd50));
    directed.push_back(mk(64'h5, 64'hA, 16'd99, 8'd5, 32'd50, 1, 0, STATUS_LIST_FULL));
    for (int s = 3; s < NSLOT; s++)
      directed.push_back(mk(64'(s) << 60, 64'(s), 16'd1, 8'd1, 32'd0));
    directed.push_back(mk(64'hDEAD, 64'hBEEF, 16'd7, 8'd1, 32'd0, 1, 0, STATUS_TABLE_FULL));
    foreach (directed[i]) send_message(directed[i]);

    // Let the pending results drain, then a reset-free random phase reusing known slots.
    s_axis_tvalid <= 0;
    while (verdicts.size() != 0) @(posedge clk);
    for (int i = 0; i < 24; i++) begin
      addr_pool_hi[i] = i < NSLOT ? sh_hi[i] : {$urandom, $urandom};
      addr_pool_lo[i] = i < NSLOT ? sh_lo[i] : {$urandom, $urandom};
    end
    clock_now = 32'd40;
    for (int i = 0; i < 1420; i++) begin
      if (i == 480) begin send_idle = 74; recv_idle = 10; end
      if (i == 960) begin send_idle = 0; recv_idle = 0; end
      if (i == 700) begin
        s_axis_tvalid <= 0;
        while (verdicts.size() != 0) @(posedge clk);
      end
      if ($urandom_range(9) < 3) clock_now += $urandom_range(6);
      if (i == 1300) clock_now = 32'hFFFF_FF00;
      slot_pick = $urandom_range(23);
      m = mk(addr_pool_hi[slot_pick], addr_pool_lo[slot_pick],
             16'($urandom_range(11)), 8'($urandom_range(40)), clock_now);
      case ($urandom_range(9))
        0: m.seq = 16'($urandom);
        1: m.life = 8'($urandom);
        2: m.now = $urandom;
        3: begin m.hi = {$urandom, $urandom}; m.lo = {$urandom, $urandom}; end
        default: ;
      endcase
      send_message(m);
    end

    s_axis_tvalid <= 0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

/* duplicate_message_filter.f */
hdl/dmf_pkg.sv
hdl/dmf_ctrl.sv
hdl/dmf_data.sv
hdl/duplicate_message_filter.sv
sim/tb.sv
